[rtl/lfc_pkg.sv]
// ============================================================================
// lfc_pkg
// Shared types, constants and the CRC16 byte update of the log frame checker.
// ============================================================================
package lfc_pkg;

    localparam int unsigned POS_W = 17;
    localparam int unsigned LEN_W = 16;
    localparam int unsigned CRC_W = 16;

    localparam logic [POS_W-1:0] POS_MAX   = 17'h1FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY  = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_INIT  = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_TOP   = 16'h8000;
    localparam logic [7:0]       SYNC_A    = 8'hEB;
    localparam logic [7:0]       SYNC_B    = 8'h90;
    localparam logic [POS_W-1:0] MIN_FRAME = 17'd10;
    localparam logic [POS_W-1:0] HDR_LEN   = 17'd8;

    localparam logic [POS_W-1:0] POS_SYNC_A  = 17'd0;
    localparam logic [POS_W-1:0] POS_SYNC_B  = 17'd1;
    localparam logic [POS_W-1:0] POS_TYPE    = 17'd2;
    localparam logic [POS_W-1:0] POS_SUBTYPE = 17'd3;
    localparam logic [POS_W-1:0] POS_LEN_HI  = 17'd6;
    localparam logic [POS_W-1:0] POS_LEN_LO  = 17'd7;

    typedef enum logic [2:0] {
        OP_HEADER,
        OP_PAYLOAD,
        OP_CRC_HI,
        OP_CRC_LO,
        OP_SKIP
    } byte_op_t;

    typedef enum logic [2:0] {
        VERDICT_OK,
        VERDICT_SHORT,
        VERDICT_SYNC,
        VERDICT_TRUNC,
        VERDICT_CRC
    } verdict_t;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic [7:0] data;
        byte_op_t   op;
        logic       eof;
        logic       too_short;
        logic       sync_bad;
        logic       truncated;
        logic [7:0] ftype;
        logic [7:0] fsubtype;
    } lfc_item_t;

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if ((c & CRC_TOP) != '0)
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[rtl/lfc_front.sv]
// ============================================================================
// lfc_front
// Tracks byte position, captures header fields and classifies each byte.
// ============================================================================
module lfc_front
    import lfc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  logic [7:0] rx_byte,
    input  logic      end_of_frame,
    output lfc_item_t item
);

    logic [POS_W-1:0] pos_reg,      pos_next;
    logic             sync_bad_reg, sync_bad_next;
    logic [7:0]       type_reg,     type_next;
    logic [7:0]       subtype_reg,  subtype_next;
    logic [LEN_W-1:0] len_reg,      len_next;

    logic [POS_W:0]   crc_pos;
    logic [POS_W-1:0] size;

    always_comb
    begin
        sync_bad_next = sync_bad_reg;
        type_next     = type_reg;
        subtype_next  = subtype_reg;
        len_next      = len_reg;

        if (pos_reg == POS_SYNC_A && rx_byte != SYNC_A)
            sync_bad_next = 1'b1;
        if (pos_reg == POS_SYNC_B && rx_byte != SYNC_B)
            sync_bad_next = 1'b1;
        if (pos_reg == POS_TYPE)
            type_next = rx_byte;
        if (pos_reg == POS_SUBTYPE)
            subtype_next = rx_byte;
        if (pos_reg == POS_LEN_HI)
            len_next = {rx_byte, len_reg[7:0]};
        if (pos_reg == POS_LEN_LO)
            len_next = {len_reg[LEN_W-1:8], rx_byte};

        crc_pos = {1'b0, HDR_LEN} + {2'b00, len_next};
        size    = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;

        item.data     = rx_byte;
        item.eof      = end_of_frame;
        item.sync_bad = sync_bad_next;
        item.ftype    = type_next;
        item.fsubtype = subtype_next;
        item.too_short = (size < MIN_FRAME);
        item.truncated = ({1'b0, size} < ({1'b0, MIN_FRAME} + {2'b00, len_next}));

        if ({1'b0, pos_reg} < crc_pos)
            item.op = (pos_reg >= HDR_LEN) ? OP_PAYLOAD : OP_HEADER;
        else if ({1'b0, pos_reg} == crc_pos)
            item.op = OP_CRC_HI;
        else if ({1'b0, pos_reg} == crc_pos + 1'b1)
            item.op = OP_CRC_LO;
        else
            item.op = OP_SKIP;

        pos_next = size;
        if (end_of_frame)
        begin
            pos_next      = '0;
            sync_bad_next = 1'b0;
            type_next     = '0;
            subtype_next  = '0;
            len_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            sync_bad_reg <= 1'b0;
            type_reg     <= '0;
            subtype_reg  <= '0;
            len_reg      <= '0;
        end
        else if (push)
        begin
            pos_reg      <= pos_next;
            sync_bad_reg <= sync_bad_next;
            type_reg     <= type_next;
            subtype_reg  <= subtype_next;
            len_reg      <= len_next;
        end
    end

endmodule

[rtl/lfc_queue.sv]
// ============================================================================
// lfc_queue
// Short FIFO of classified bytes between the front and back sections.
// ============================================================================
module lfc_queue
    import lfc_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  lfc_item_t push_item,
    input  logic      pop,
    output logic      full,
    output logic      head_valid,
    output lfc_item_t head_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    lfc_item_t           slot_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg,  count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

[rtl/lfc_back.sv]
// ============================================================================
// lfc_back
// Runs the CRC, collects the received CRC and registers payload and verdicts.
// ============================================================================
module lfc_back
    import lfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  lfc_item_t  head_item,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       item_kind,
    output logic [7:0] payload_byte,
    output logic [7:0] frame_type,
    output logic [7:0] frame_subtype,
    output logic [2:0] verdict
);

    logic [CRC_W-1:0] crc_reg,  crc_next;
    logic [CRC_W-1:0] rcrc_reg, rcrc_next;
    logic             valid_reg, valid_next;
    logic             kind_reg,  kind_next;
    logic [7:0]       data_reg,  data_next;
    logic [7:0]       type_reg,  type_next;
    logic [7:0]       sub_reg,   sub_next;
    verdict_t         verdict_reg, verdict_next;

    logic [CRC_W-1:0] crc_upd;
    logic [CRC_W-1:0] rcrc_upd;

    assign pop = head_valid && (!valid_reg || !out_stall);

    always_comb
    begin
        crc_upd  = crc_reg;
        rcrc_upd = rcrc_reg;
        case (head_item.op)
            OP_HEADER, OP_PAYLOAD: crc_upd  = crc_byte(crc_reg, head_item.data);
            OP_CRC_HI:             rcrc_upd = {head_item.data, rcrc_reg[7:0]};
            OP_CRC_LO:             rcrc_upd = {rcrc_reg[CRC_W-1:8], head_item.data};
            default:               ;
        endcase

        crc_next     = crc_reg;
        rcrc_next    = rcrc_reg;
        valid_next   = valid_reg && out_stall;
        kind_next    = kind_reg;
        data_next    = data_reg;
        type_next    = type_reg;
        sub_next     = sub_reg;
        verdict_next = verdict_reg;

        if (pop)
        begin
            crc_next   = crc_upd;
            rcrc_next  = rcrc_upd;
            valid_next = 1'b0;
            if (head_item.eof)
            begin
                valid_next = 1'b1;
                kind_next  = KIND_VERDICT;
                data_next  = '0;
                type_next  = head_item.ftype;
                sub_next   = head_item.fsubtype;
                if (head_item.too_short)
                    verdict_next = VERDICT_SHORT;
                else if (head_item.sync_bad)
                    verdict_next = VERDICT_SYNC;
                else if (head_item.truncated)
                    verdict_next = VERDICT_TRUNC;
                else if (rcrc_upd != crc_upd)
                    verdict_next = VERDICT_CRC;
                else
                    verdict_next = VERDICT_OK;
                if (head_item.too_short || head_item.sync_bad)
                begin
                    type_next = '0;
                    sub_next  = '0;
                end
                crc_next  = CRC_INIT;
                rcrc_next = '0;
            end
            else if (head_item.op == OP_PAYLOAD)
            begin
                valid_next   = 1'b1;
                kind_next    = KIND_PAYLOAD;
                data_next    = head_item.data;
                type_next    = '0;
                sub_next     = '0;
                verdict_next = VERDICT_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_INIT;
            rcrc_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg   <= crc_next;
            rcrc_reg  <= rcrc_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        data_reg    <= data_next;
        type_reg    <= type_next;
        sub_reg     <= sub_next;
        verdict_reg <= verdict_next;
    end

    assign out_valid     = valid_reg;
    assign item_kind     = kind_reg;
    assign payload_byte  = data_reg;
    assign frame_type    = type_reg;
    assign frame_subtype = sub_reg;
    assign verdict       = verdict_reg;

endmodule

[rtl/log_frame_checker_top.sv]
// ============================================================================
// log_frame_checker_top
// Byte-serial checker for sync-headed log frames with a CRC16-CCITT trailer.
// ============================================================================
// Takes one byte per cycle and keeps that rate with a stall-free output. Each
// byte is classified by the front section (position, header capture) in the
// cycle it is taken, waits in a QUEUE_DEPTH-entry FIFO, and is retired by the
// back section, which runs the byte-wide CRC update and loads the output
// register; a result passes through the FIFO slot and the output register
// before it is offered.
// Payload bytes come out as they arrive; the last byte of a frame yields one
// verdict (ok, too short, bad sync, truncated, CRC mismatch) with type and
// subtype, and the frame state clears for the next frame.
module log_frame_checker_top
    import lfc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       end_of_frame,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       item_kind,
    output logic [7:0] payload_byte,
    output logic [7:0] frame_type,
    output logic [7:0] frame_subtype,
    output logic [2:0] verdict
);

    lfc_item_t front_item;
    lfc_item_t head_item;
    logic      push;
    logic      pop;
    logic      full;
    logic      head_valid;

    assign in_stall = full;
    assign push     = in_valid && !full;

    lfc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .rx_byte      (rx_byte),
        .end_of_frame (end_of_frame),
        .item         (front_item)
    );

    lfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (front_item),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    lfc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_item     (head_item),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .item_kind     (item_kind),
        .payload_byte  (payload_byte),
        .frame_type    (frame_type),
        .frame_subtype (frame_subtype),
        .verdict       (verdict)
    );

endmodule
